// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers that are clocked on clk_i and held off
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A general property, sampled on every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// An implication that must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  `ASSERT_PROP(label, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/sttl_pkg.sv =====
// ----------------------------------------------------------------------------
// sttl_pkg
// Types and constants shared by the strip to triangle list converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sttl_pkg;

  localparam int unsigned IndexW = 16;
  localparam int unsigned CountW = 22;
  localparam int unsigned MaxMeshIndices = 1048576;
  localparam int unsigned CountMask = (1 << CountW) - 1;
  localparam int unsigned CountLimitInt =
      (MaxMeshIndices * 3 > CountMask) ? CountMask : MaxMeshIndices * 3;
  localparam logic [CountW-1:0] CountLimit = CountLimitInt[CountW-1:0];
  localparam logic [IndexW-1:0] RestartIndex = 16'hFFFF;
  localparam logic [1:0] RunFull = 2'd2;

  typedef struct packed {
    logic [IndexW-1:0] strip_index;
    logic              mesh_end;
  } in_word_t;

  typedef struct packed {
    logic [IndexW-1:0] corner_a;
    logic [IndexW-1:0] corner_b;
    logic [IndexW-1:0] corner_c;
    logic              has_triangle;
    logic              mesh_done;
    logic [CountW-1:0] emitted_count;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctrl_t;

endpackage

// ===== hw/rtl/strip_to_triangle_list.sv =====
// ----------------------------------------------------------------------------
// strip_to_triangle_list
// Converts a triangle strip index stream with restarts into a triangle list.
// ----------------------------------------------------------------------------
// Each input word carries one strip index and a mesh end flag; each output
// word carries one triangle, a mesh end report, or both. Both channels use
// valid and ready. The enable register is written through cfg_we_i and
// resets to one.
// A word accepted into the input register is turned into its result by the
// combinational assembler; the result word is registered in the result
// register and offered from there. The block takes one word per cycle when
// the receiver keeps up; words that yield no result leave the input register
// even while the receiver stalls. While it stalls, the result and input
// registers each hold one word, after which in_ready_o drops. Reset clears
// the run state, index total and both valid flags, and sets enable to one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module strip_to_triangle_list (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sttl_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sttl_pkg::out_word_t out_word_o
);
  import sttl_pkg::*;

  `include "assert_macros.svh"

  logic        enable_q;
  logic        enable_d;
  logic        s1_valid;
  in_word_t    s1_word;
  logic        emit;
  out_word_t   result;
  logic        can_load;
  stage_ctrl_t ctrl;

  assign enable_d = cfg_we_i ? cfg_wdata_i : enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else begin
      enable_q <= enable_d;
    end
  end

  assign ctrl.valid   = s1_valid;
  assign ctrl.advance = s1_valid && (!emit || can_load);

  sttl_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .take_i     (ctrl.advance),
    .valid_o    (s1_valid),
    .word_o     (s1_word)
  );

  sttl_assembler u_assembler (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .enable_i (enable_q),
    .ctrl_i   (ctrl),
    .word_i   (s1_word),
    .emit_o   (emit),
    .result_o (result)
  );

  sttl_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ctrl.advance && emit),
    .word_i      (result),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  `ASSERT_IMPLIES(a_result_has_cause, out_valid_o,
      out_word_o.has_triangle || out_word_o.mesh_done,
      "result word carries neither a triangle nor a mesh end")
  `ASSERT_IMPLIES(a_triangle_distinct, out_valid_o && out_word_o.has_triangle,
      (out_word_o.corner_a != out_word_o.corner_b)
      && (out_word_o.corner_a != out_word_o.corner_c)
      && (out_word_o.corner_b != out_word_o.corner_c),
      "degenerate triangle emitted")
  `ASSERT_IMPLIES(a_empty_corners, out_valid_o && !out_word_o.has_triangle,
      (out_word_o.corner_a == '0) && (out_word_o.corner_b == '0)
      && (out_word_o.corner_c == '0),
      "corners not cleared on a word without a triangle")
  `ASSERT_IMPLIES(a_count_limit, out_valid_o,
      out_word_o.emitted_count <= CountLimit,
      "emitted count above its limit")

endmodule

// ===== hw/rtl/sttl_in_stage.sv =====
// ----------------------------------------------------------------------------
// sttl_in_stage
// Input register that holds one accepted word until the assembler takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sttl_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sttl_pkg::in_word_t in_word_i,
  input  logic              take_i,
  output logic              valid_o,
  output sttl_pkg::in_word_t word_o
);
  import sttl_pkg::*;

  logic     valid_q;
  logic     valid_d;
  in_word_t word_q;
  logic     load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= in_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== hw/rtl/sttl_assembler.sv =====
// ----------------------------------------------------------------------------
// sttl_assembler
// Strip run state and triangle forming, one index per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sttl_assembler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                enable_i,
  input  sttl_pkg::stage_ctrl_t ctrl_i,
  input  sttl_pkg::in_word_t  word_i,
  output logic                emit_o,
  output sttl_pkg::out_word_t result_o
);
  import sttl_pkg::*;

  logic [IndexW-1:0] older_q, older_d;
  logic [IndexW-1:0] newer_q, newer_d;
  logic [1:0]        run_pos_q, run_pos_d;
  logic              odd_q, odd_d;
  logic [CountW-1:0] total_q, total_d;

  logic              restart;
  logic              run_full;
  logic [IndexW-1:0] corner_a;
  logic [IndexW-1:0] corner_b;
  logic              tri_ok;
  logic [CountW:0]   total_sum;
  logic [CountW-1:0] total_tri;

  assign restart  = (word_i.strip_index == RestartIndex);
  assign run_full = (run_pos_q == RunFull);
  assign corner_a = odd_q ? newer_q : older_q;
  assign corner_b = odd_q ? older_q : newer_q;
  assign tri_ok   = enable_i && !restart && run_full && (corner_a != corner_b)
                    && (corner_a != word_i.strip_index)
                    && (corner_b != word_i.strip_index);

  assign total_sum = {1'b0, total_q} + (CountW + 1)'(3);
  always_comb begin
    total_tri = total_q;
    if (tri_ok) begin
      total_tri = (total_sum > {1'b0, CountLimit}) ? CountLimit
                                                    : total_sum[CountW-1:0];
    end
  end

  always_comb begin
    result_o.corner_a      = tri_ok ? corner_a : '0;
    result_o.corner_b      = tri_ok ? corner_b : '0;
    result_o.corner_c      = tri_ok ? word_i.strip_index : '0;
    result_o.has_triangle  = tri_ok;
    result_o.mesh_done     = word_i.mesh_end;
    result_o.emitted_count = total_tri;
  end

  assign emit_o = ctrl_i.valid && (tri_ok || word_i.mesh_end);

  always_comb begin
    older_d   = older_q;
    newer_d   = newer_q;
    run_pos_d = run_pos_q;
    odd_d     = odd_q;
    total_d   = total_q;
    priority if (word_i.mesh_end) begin
      older_d   = '0;
      newer_d   = '0;
      run_pos_d = '0;
      odd_d     = 1'b0;
      total_d   = '0;
    end else if (enable_i && restart) begin
      run_pos_d = '0;
      odd_d     = 1'b0;
    end else if (enable_i) begin
      older_d   = newer_q;
      newer_d   = word_i.strip_index;
      run_pos_d = run_full ? RunFull : run_pos_q + 2'd1;
      odd_d     = !odd_q;
      total_d   = total_tri;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q   <= '0;
      newer_q   <= '0;
      run_pos_q <= '0;
      odd_q     <= 1'b0;
      total_q   <= '0;
    end else if (ctrl_i.advance) begin
      older_q   <= older_d;
      newer_q   <= newer_d;
      run_pos_q <= run_pos_d;
      odd_q     <= odd_d;
      total_q   <= total_d;
    end
  end

endmodule

// ===== hw/rtl/sttl_out_stage.sv =====
// ----------------------------------------------------------------------------
// sttl_out_stage
// Result register that holds one word until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sttl_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  sttl_pkg::out_word_t word_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sttl_pkg::out_word_t out_word_o
);
  import sttl_pkg::*;

  logic      valid_q;
  logic      valid_d;
  out_word_t word_q;

  assign can_load_o = !valid_q || out_ready_i;
  assign valid_d    = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

// ===== verif/tb_strip_to_triangle_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strip_to_triangle_list
// Self-checking testbench for the strip to triangle list converter.
// ----------------------------------------------------------------------------
// A short directed table covers index extremes, restarts, degenerate
// triangles, short meshes and the enable register. A random part follows,
// made mostly of meshes with random content, in phases with enable on and
// off. A local triangle assembler predicts the result words, except where a
// table row gives its own, and a checker compares each accepted result word
// field by field. Both sides idle at random, except during one calm phase.
// ----------------------------------------------------------------------------

module tb_strip_to_triangle_list;
  import sttl_pkg::*;

  typedef enum logic {ROW_WORD, ROW_ENABLE} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [IndexW-1:0] idx;
    logic              last;
    logic              typed;
    out_word_t         want;
  } dir_row_t;

  localparam int unsigned NumRows = 27;

  localparam dir_row_t DirTable [NumRows] = '{
    '{ROW_WORD,   16'h0000, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'h0001, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'h0002, 1'b0, 1'b1,
      '{16'h0000, 16'h0001, 16'h0002, 1'b1, 1'b0, 22'd3}},
    '{ROW_WORD,   16'h0003, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'hFFFE, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'hFFFF, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'h0005, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'h0005, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'h0007, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'h0007, 1'b1, 1'b0, '0},
    '{ROW_WORD,   16'hFFFF, 1'b1, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 22'd0}},
    '{ROW_WORD,   16'h1234, 1'b1, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 22'd0}},
    '{ROW_WORD,   16'hFFFE, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'h0000, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'h8000, 1'b1, 1'b0, '0},
    '{ROW_WORD,   16'h0100, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'h0200, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'h0300, 1'b0, 1'b0, '0},
    '{ROW_ENABLE, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'h0400, 1'b0, 1'b0, '0},
    '{ROW_ENABLE, 16'h0001, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'h0400, 1'b0, 1'b0, '0},
    '{ROW_ENABLE, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'hFFFF, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'h0500, 1'b1, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 22'd6}},
    '{ROW_ENABLE, 16'h0001, 1'b0, 1'b0, '0},
    '{ROW_WORD,   16'h0001, 1'b1, 1'b0, '0}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  logic              asm_enable = 1'b1;
  logic [IndexW-1:0] older_idx = '0;
  logic [IndexW-1:0] newer_idx = '0;
  logic [1:0]        run_pos = '0;
  logic              odd_pos = 1'b0;
  logic [CountW-1:0] index_total = '0;

  out_word_t expected_reports[$];
  int        mismatches = 0;
  bit        calm = 1'b0;

  strip_to_triangle_list dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit assemble_triangle(input in_word_t w, output out_word_t r);
    logic [IndexW-1:0] a;
    logic [IndexW-1:0] b;
    logic [IndexW-1:0] c;
    logic [IndexW-1:0] t;
    logic [CountW:0]   sum;
    bit                formed;
    formed = 1'b0;
    a = '0;
    b = '0;
    c = '0;
    if (asm_enable) begin
      if (w.strip_index == RestartIndex) begin
        run_pos = '0;
        odd_pos = 1'b0;
      end else begin
        if (run_pos == RunFull) begin
          a = older_idx;
          b = newer_idx;
          c = w.strip_index;
          if (odd_pos) begin
            t = a;
            a = b;
            b = t;
          end
          if (a != b && a != c && b != c) begin
            formed = 1'b1;
            sum = {1'b0, index_total} + (CountW + 1)'(3);
            index_total = (sum > {1'b0, CountLimit}) ? CountLimit : sum[CountW-1:0];
          end
        end
        older_idx = newer_idx;
        newer_idx = w.strip_index;
        if (run_pos != RunFull) run_pos = run_pos + 1'b1;
        odd_pos = ~odd_pos;
      end
    end
    if (!formed) begin
      a = '0;
      b = '0;
      c = '0;
    end
    r.corner_a = a;
    r.corner_b = b;
    r.corner_c = c;
    r.has_triangle = formed;
    r.mesh_done = w.mesh_end;
    r.emitted_count = index_total;
    if (w.mesh_end) begin
      older_idx = '0;
      newer_idx = '0;
      run_pos = '0;
      odd_pos = 1'b0;
      index_total = '0;
    end
    return formed || w.mesh_end;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    out_word_t r;
    bit        has_report;
    if (!calm && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 11);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    has_report = assemble_triangle(w, r);
    if (typed) expected_reports = {expected_reports, want};
    else if (has_report) expected_reports = {expected_reports, r};
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_enable(input logic value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    asm_enable = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_meshes(input int quota);
    in_word_t w;
    int       sent;
    int       len;
    bit       wide;
    logic [IndexW-1:0] base;
    sent = 0;
    while (sent < quota) begin
      len  = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      wide = ($urandom_range(3) == 0);
      base = IndexW'($urandom);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(15) == 0) w.strip_index = RestartIndex;
        else if (wide) w.strip_index = IndexW'($urandom);
        else w.strip_index = base + IndexW'($urandom_range(5));
        w.mesh_end = (k == len - 1) || ($urandom_range(63) == 0);
        send_word(w, 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic check_report(input out_word_t want, input out_word_t got);
    if (got.corner_a !== want.corner_a) begin
      $error("corner_a: expected %h, actual %h", want.corner_a, got.corner_a);
      mismatches++;
    end
    if (got.corner_b !== want.corner_b) begin
      $error("corner_b: expected %h, actual %h", want.corner_b, got.corner_b);
      mismatches++;
    end
    if (got.corner_c !== want.corner_c) begin
      $error("corner_c: expected %h, actual %h", want.corner_c, got.corner_c);
      mismatches++;
    end
    if (got.has_triangle !== want.has_triangle) begin
      $error("has_triangle: expected %b, actual %b", want.has_triangle, got.has_triangle);
      mismatches++;
    end
    if (got.mesh_done !== want.mesh_done) begin
      $error("mesh_done: expected %b, actual %b", want.mesh_done, got.mesh_done);
      mismatches++;
    end
    if (got.emitted_count !== want.emitted_count) begin
      $error("emitted_count: expected %0d, actual %0d", want.emitted_count,
             got.emitted_count);
      mismatches++;
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 11);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result word: %p", out_word_o);
        mismatches++;
      end else begin
        check_report(expected_reports.pop_front(), out_word_o);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    in_word_t w;
    logic     en;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      if (DirTable[i].kind == ROW_ENABLE) begin
        write_enable(DirTable[i].idx[0]);
      end else begin
        w.strip_index = DirTable[i].idx;
        w.mesh_end    = DirTable[i].last;
        send_word(w, DirTable[i].typed, DirTable[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      en = !(ph == 3 || ph == 6);
      write_enable(en);
      calm = (ph == 2);
      send_meshes(en ? 85 : 30);
    end
    calm = 1'b0;

    settle();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sttl_pkg.sv
hw/rtl/sttl_in_stage.sv
hw/rtl/sttl_assembler.sv
hw/rtl/sttl_out_stage.sv
hw/rtl/strip_to_triangle_list.sv
verif/tb_strip_to_triangle_list.sv
